### rtl/i2crs_pkg.sv
// ----------------------------------------------------------------------------
// i2crs_pkg
// Shared types and constants of the rangefinder I2C transaction sequencer.
// ----------------------------------------------------------------------------
package i2crs_pkg;

    // Sequencer states, one per bus step of a transaction.
    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_ADDR_SENT = 4'd1,
        ST_REG_SENT  = 4'd2,
        ST_VAL_SENT  = 4'd3,
        ST_SETTLE    = 4'd4,
        ST_PTR_START = 4'd5,
        ST_PTR_ADDR  = 4'd6,
        ST_PTR_REG   = 4'd7,
        ST_PTR_STOP  = 4'd8,
        ST_RD_START  = 4'd9,
        ST_RD_ADDR   = 4'd10,
        ST_RD_HIGH   = 4'd11,
        ST_ACK_HIGH  = 4'd12,
        ST_RD_LOW    = 4'd13,
        ST_NACK_LOW  = 4'd14,
        ST_RD_STOP   = 4'd15
    } t_seq_state;

    // Commands handed to the bus controller.
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_TX    = 3'd3,
        CMD_RCV   = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6
    } t_bus_cmd;

    // Item kinds on the input stream.
    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_EVENT   = 1'b1;

    // Configuration register indexes.
    localparam int  CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_REGISTER = 2'd1;

    // Reset values.
    localparam logic [6:0] DEVICE_ADDRESS_RST    = 7'h62;
    localparam logic [6:0] DISTANCE_REGISTER_RST = 7'h0f;
    localparam logic [7:0] PENDING_REG_RST       = 8'h04;
    localparam logic [7:0] PENDING_VAL_RST       = 8'h09;

    localparam logic [7:0] AUTO_INC_BIT = 8'h80;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    // Fields of one input item after unpacking.
    typedef struct packed {
        logic       func;
        logic [7:0] reg_addr;
        logic [7:0] reg_value;
        logic       read_after;
        logic       nack_seen;
        logic [7:0] rx_byte;
    } t_item;

    // Fields of one result item.
    typedef struct packed {
        t_bus_cmd    bus_cmd;
        logic [7:0]  tx_byte;
        logic [15:0] range_value;
        logic        bus_error;
    } t_result;

    // Configuration values seen by the sequencer.
    typedef struct packed {
        logic [6:0] device_address;
        logic [6:0] distance_register;
    } t_cfg;

endpackage

### rtl/i2crs_cfg.sv
// ----------------------------------------------------------------------------
// i2crs_cfg
// Configuration register file: device address and distance register.
// ----------------------------------------------------------------------------
module i2crs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [i2crs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [6:0]                    i_cfg_data,
    output i2crs_pkg::t_cfg               o_cfg
);
    import i2crs_pkg::*;

    logic [6:0] r_device_address;
    logic [6:0] r_distance_register;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address    <= DEVICE_ADDRESS_RST;
            r_distance_register <= DISTANCE_REGISTER_RST;
        end else if (i_cfg_valid) begin
            // Writes to indexes beyond the register list are dropped.
            if (i_cfg_index == CFG_DEVICE_ADDRESS) begin
                r_device_address <= i_cfg_data;
            end
            if (i_cfg_index == CFG_DISTANCE_REGISTER) begin
                r_distance_register <= i_cfg_data;
            end
        end
    end

    assign o_cfg.device_address    = r_device_address;
    assign o_cfg.distance_register = r_distance_register;

endmodule

### rtl/i2crs_fsm.sv
// ----------------------------------------------------------------------------
// i2crs_fsm
// Transaction state machine: one state step per accepted event item, producing
// the bus command and the status that follows that step.
// ----------------------------------------------------------------------------
module i2crs_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  i2crs_pkg::t_item   i_item,
    input  i2crs_pkg::t_cfg    i_cfg,
    output i2crs_pkg::t_result o_result
);
    import i2crs_pkg::*;

    t_seq_state  r_state,        n_state;
    logic        r_nack_latch,   n_nack_latch;
    logic        r_error_flag,   n_error_flag;
    logic [15:0] r_distance,     n_distance;
    logic [7:0]  r_pending_reg,  n_pending_reg;
    logic [7:0]  r_pending_val,  n_pending_val;
    logic        r_pending_read, n_pending_read;

    t_bus_cmd    cmd;
    logic [7:0]  tx;
    logic [7:0]  addr_wr;
    logic [7:0]  addr_rd;

    assign addr_wr = {i_cfg.device_address, 1'b0};
    assign addr_rd = {i_cfg.device_address, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_nack_latch   <= 1'b0;
            r_error_flag   <= 1'b0;
            r_distance     <= '0;
            r_pending_reg  <= PENDING_REG_RST;
            r_pending_val  <= PENDING_VAL_RST;
            r_pending_read <= 1'b0;
        end else if (i_accept) begin
            r_state        <= n_state;
            r_nack_latch   <= n_nack_latch;
            r_error_flag   <= n_error_flag;
            r_distance     <= n_distance;
            r_pending_reg  <= n_pending_reg;
            r_pending_val  <= n_pending_val;
            r_pending_read <= n_pending_read;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_nack_latch   = r_nack_latch;
        n_error_flag   = r_error_flag;
        n_distance     = r_distance;
        n_pending_reg  = r_pending_reg;
        n_pending_val  = r_pending_val;
        n_pending_read = r_pending_read;
        cmd            = CMD_NONE;
        tx             = 8'h00;

        if (i_item.func == FUNC_REQUEST) begin
            // A request while a transaction is running is dropped.
            if (r_state == ST_IDLE) begin
                n_pending_reg  = i_item.reg_addr;
                n_pending_val  = i_item.reg_value;
                n_pending_read = i_item.read_after;
                cmd            = CMD_START;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    // The error of the previous transaction becomes visible now.
                    n_error_flag = r_nack_latch;
                    cmd          = CMD_TX;
                    tx           = addr_wr;
                    n_state      = ST_ADDR_SENT;
                end
                ST_ADDR_SENT: begin
                    if (i_item.nack_seen) begin
                        n_nack_latch = 1'b1;
                        cmd          = CMD_STOP;
                        n_state      = ST_SETTLE;
                    end else begin
                        n_nack_latch = 1'b0;
                        cmd          = CMD_TX;
                        tx           = r_pending_reg;
                        n_state      = ST_REG_SENT;
                    end
                end
                ST_REG_SENT: begin
                    if (i_item.nack_seen) begin
                        n_nack_latch = 1'b1;
                        cmd          = CMD_STOP;
                        n_state      = ST_SETTLE;
                    end else begin
                        cmd     = CMD_TX;
                        tx      = r_pending_val;
                        n_state = ST_VAL_SENT;
                    end
                end
                ST_VAL_SENT: begin
                    cmd = CMD_STOP;
                    if (i_item.nack_seen) begin
                        n_nack_latch = 1'b1;
                        n_state      = ST_SETTLE;
                    end else if (!r_pending_read) begin
                        n_state = ST_SETTLE;
                    end else begin
                        n_state = ST_PTR_START;
                    end
                end
                ST_SETTLE: begin
                    n_state = ST_IDLE;
                end
                ST_PTR_START: begin
                    cmd     = CMD_START;
                    n_state = ST_PTR_ADDR;
                end
                ST_PTR_ADDR: begin
                    cmd     = CMD_TX;
                    tx      = addr_wr;
                    n_state = ST_PTR_REG;
                end
                ST_PTR_REG: begin
                    if (i_item.nack_seen) begin
                        n_nack_latch = 1'b1;
                        cmd          = CMD_STOP;
                        n_state      = ST_SETTLE;
                    end else begin
                        cmd     = CMD_TX;
                        tx      = AUTO_INC_BIT | {1'b0, i_cfg.distance_register};
                        n_state = ST_PTR_STOP;
                    end
                end
                ST_PTR_STOP: begin
                    cmd = CMD_STOP;
                    if (i_item.nack_seen) begin
                        n_nack_latch = 1'b1;
                        n_state      = ST_SETTLE;
                    end else begin
                        n_state = ST_RD_START;
                    end
                end
                ST_RD_START: begin
                    cmd     = CMD_START;
                    n_state = ST_RD_ADDR;
                end
                ST_RD_ADDR: begin
                    cmd     = CMD_TX;
                    tx      = addr_rd;
                    n_state = ST_RD_HIGH;
                end
                ST_RD_HIGH: begin
                    if (i_item.nack_seen) begin
                        n_nack_latch = 1'b1;
                        cmd          = CMD_STOP;
                        n_state      = ST_SETTLE;
                    end else begin
                        cmd     = CMD_RCV;
                        n_state = ST_ACK_HIGH;
                    end
                end
                ST_ACK_HIGH: begin
                    n_distance = {i_item.rx_byte, 8'h00};
                    cmd        = CMD_ACK;
                    n_state    = ST_RD_LOW;
                end
                ST_RD_LOW: begin
                    cmd     = CMD_RCV;
                    n_state = ST_NACK_LOW;
                end
                ST_NACK_LOW: begin
                    n_distance = r_distance | {8'h00, i_item.rx_byte};
                    cmd        = CMD_NACK;
                    n_state    = ST_RD_STOP;
                end
                default: begin
                    // Final stop of a read transaction.
                    cmd     = CMD_STOP;
                    n_state = ST_SETTLE;
                end
            endcase
        end
    end

    assign o_result.bus_cmd     = cmd;
    assign o_result.tx_byte     = tx;
    assign o_result.range_value = n_distance;
    assign o_result.bus_error   = n_error_flag;

    // A request never moves the state machine.
    a_request_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_item.func == FUNC_REQUEST) |=> r_state == $past(r_state))
        else $error("request changed the sequencer state");

    // The settle step always returns to idle.
    a_settle_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_item.func == FUNC_EVENT) && (r_state == ST_SETTLE)
        |=> r_state == ST_IDLE)
        else $error("settle step did not return to idle");

    // The reported error only moves on the first event of a transaction.
    a_error_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_accept && (i_item.func == FUNC_EVENT) && (r_state == ST_IDLE))
        |=> $stable(r_error_flag))
        else $error("error flag changed outside the idle event");

    // Distance only changes on the two receive-answer steps.
    a_distance_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_accept && (r_state == ST_ACK_HIGH || r_state == ST_NACK_LOW))
        |=> $stable(r_distance))
        else $error("distance changed outside a receive step");

endmodule

### rtl/i2c_rangefinder_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_rangefinder_transaction_sequencer
// Each accepted input item yields one result item, held in the output register
// from the next cycle. Throughput: one item per cycle; the state step and the
// command mux sit between the input handshake and a single output register.
// The output register drains while a new item enters, so only a stalled,
// full output holds off the input side.
// Reset (i_rst_n low, synchronous) empties the output and restores state.
// ----------------------------------------------------------------------------
module i2c_rangefinder_transaction_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] reg_addr, [15:8] reg_value, [16] read_after, [17] nack_seen,
    // [25:18] rx_byte, [31:26] zero
    input  logic [i2crs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] func
    input  logic                                s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] bus_cmd, [10:3] tx_byte, [26:11] range_value, [27] bus_error,
    // [31:28] zero
    output logic [i2crs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // Configuration writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2crs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [6:0]                          i_cfg_data
);
    import i2crs_pkg::*;

    t_item   item;
    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    assign item.reg_addr   = s_axis_tdata[7:0];
    assign item.reg_value  = s_axis_tdata[15:8];
    assign item.read_after = s_axis_tdata[16];
    assign item.nack_seen  = s_axis_tdata[17];
    assign item.rx_byte    = s_axis_tdata[25:18];
    assign item.func       = s_axis_tuser;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    i2crs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    i2crs_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_out.bus_error, r_out.range_value,
                            r_out.tx_byte, r_out.bus_cmd};

endmodule
